FILE: sv/wbps_pkg.sv
// Package for the wildcard byte pattern search block.
// Holds the configuration bundle type, register indexes and fixed widths.
// No dependencies; used by every module of the block.
package wbps_pkg;

  // Width of the pattern length register and the number of pattern bytes it can name.
  localparam int unsigned LenW        = 5;
  localparam int unsigned PatBytes    = 16;
  localparam int unsigned PatWordW    = 64;
  localparam int unsigned CfgIndexW   = 2;
  localparam int unsigned ResultOffW  = 32;

  // A pattern byte with this value matches any data byte.
  localparam logic [7:0] WildcardByte = 8'h3F;

  // Register indexes on the configuration channel.
  localparam logic [CfgIndexW-1:0] RegPatternLength = 2'd0;
  localparam logic [CfgIndexW-1:0] RegPatternLow    = 2'd1;
  localparam logic [CfgIndexW-1:0] RegPatternHigh   = 2'd2;

  typedef struct packed {
    logic [LenW-1:0]     pattern_length;
    logic [PatWordW-1:0] pattern_low;
    logic [PatWordW-1:0] pattern_high;
  } pattern_cfg_t;

endpackage

FILE: sv/wbps_cfg.sv
// Configuration register file of the wildcard byte pattern search block.
// Decodes register writes into the pattern bundle; depends on wbps_pkg.
module wbps_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wbps_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [wbps_pkg::PatWordW-1:0]  cfg_data_i,
  output wbps_pkg::pattern_cfg_t         cfg_o
);
  import wbps_pkg::*;

  pattern_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegPatternLength: cfg_d.pattern_length = cfg_data_i[LenW-1:0];
        RegPatternLow:    cfg_d.pattern_low    = cfg_data_i;
        RegPatternHigh:   cfg_d.pattern_high   = cfg_data_i;
        default:          cfg_d                = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_length <= LenW'(1);
      cfg_q.pattern_low    <= '0;
      cfg_q.pattern_high   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/wbps_match.sv
// Parallel window comparator of the wildcard byte pattern search block.
// Clamps the pattern length and checks every pattern byte; depends on wbps_pkg.
module wbps_match #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic [7:0]                  win_i [MAX_PATTERN],
  input  wbps_pkg::pattern_cfg_t      cfg_i,
  output logic [wbps_pkg::LenW-1:0]   used_len_o,
  output logic                        match_o
);
  import wbps_pkg::*;

  localparam int unsigned SlotW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [2*PatWordW-1:0] pat_bytes;
  logic [LenW-1:0]       used_len;
  logic [MAX_PATTERN-1:0] byte_ok;

  assign pat_bytes = {cfg_i.pattern_high, cfg_i.pattern_low};

  // Length 0 counts as 1, anything above the window depth counts as the depth.
  always_comb begin
    if (cfg_i.pattern_length == '0) begin
      used_len = LenW'(1);
    end else if (cfg_i.pattern_length > LenW'(MAX_PATTERN)) begin
      used_len = LenW'(MAX_PATTERN);
    end else begin
      used_len = cfg_i.pattern_length;
    end
  end

  // Pattern byte j lines up with the byte that arrived used_len-1-j items ago.
  always_comb begin
    logic [LenW-1:0] slot;
    logic [7:0]      pat;
    for (int unsigned j = 0; j < MAX_PATTERN; j++) begin
      slot = used_len - LenW'(1) - LenW'(j);
      pat  = pat_bytes[8*j +: 8];
      byte_ok[j] = (LenW'(j) >= used_len) || (pat == WildcardByte) ||
                   (pat == win_i[slot[SlotW-1:0]]);
    end
  end

  assign used_len_o = used_len;
  assign match_o    = &byte_ok;

endmodule

FILE: sv/wildcard_byte_pattern_search.sv
// Top level of the wildcard byte pattern search block.
// Holds the input stage, the region state and the result register;
// depends on wbps_pkg, wbps_cfg and wbps_match.
//
//  Channel   Direction  Signals                          Contents
//  --------  ---------  -------------------------------  -------------------------------
//  s_axis    in         tvalid tready tdata tuser tlast  region bytes, one per transaction
//  m_axis    out        tvalid tready tdata tuser        one result per region
//  cfg       in         valid ready index data           pattern length and pattern bytes
//
// One byte is accepted per cycle when the result side keeps up. A byte waits
// in the input register and is compared against the pattern over the whole
// window there; once it advances, its result appears on m_axis the cycle after.
// The comparator sits between the input register and the result register.
// Reset clears the window, the position, the done flag and both valid flags.
// When a result waits on m_axis and the sink stalls, the input register still
// takes one more byte; further bytes stall until the result is taken.
module wildcard_byte_pattern_search #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
  input  logic                            s_axis_tuser,  // [0] first_byte
  input  logic                            s_axis_tlast,  // last_byte
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [wbps_pkg::ResultOffW-1:0] m_axis_tdata,  // [31:0] match_offset
  output logic                            m_axis_tuser,  // [0] found
  // Configuration writes.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wbps_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [wbps_pkg::PatWordW-1:0]   cfg_data_i
);
  import wbps_pkg::*;

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_data_q;
  logic       in_first_q, in_last_q;

  // Region state.
  logic [7:0]             win_q [MAX_PATTERN];
  logic [7:0]             win_d [MAX_PATTERN];
  logic [OFFSET_BITS-1:0] pos_q, pos_d, pos_base;
  logic                   done_q, done_d, done_base;

  // Result register.
  logic                  out_valid_q;
  logic                  out_found_q, out_found_d;
  logic [ResultOffW-1:0] out_offset_q, out_offset_d;

  pattern_cfg_t    cfg;
  logic [LenW-1:0] used_len;
  logic            window_match;
  logic            out_free, advance, active, hit, produce;
  logic [OFFSET_BITS-1:0] diff;
  logic [63:0]            diff_ext;

  wbps_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The result register frees up either when it is empty or when it is taken now.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  // A first byte clears the region before the byte itself is taken.
  assign pos_base  = in_first_q ? '0 : pos_q;
  assign done_base = in_first_q ? 1'b0 : done_q;
  assign active    = !done_base;

  // Shifted window with the new byte in slot 0; a first byte clears the other slots.
  always_comb begin
    win_d[0] = in_data_q;
    for (int unsigned i = 1; i < MAX_PATTERN; i++) begin
      win_d[i] = in_first_q ? 8'h00 : win_q[i-1];
    end
  end

  // The byte position saturates at all ones.
  assign pos_d = (&pos_base) ? pos_base : pos_base + OFFSET_BITS'(1);

  wbps_match #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_match (
    .win_i     (win_d),
    .cfg_i     (cfg),
    .used_len_o(used_len),
    .match_o   (window_match)
  );

  // A window match only counts once enough bytes have arrived.
  assign hit      = window_match && (pos_d >= OFFSET_BITS'(used_len));
  assign diff     = pos_d - OFFSET_BITS'(used_len);
  assign diff_ext = 64'(diff);
  assign produce  = active && (hit || in_last_q);

  // A match on the last byte wins over the not-found result.
  assign out_found_d  = hit;
  assign out_offset_d = hit ? diff_ext[ResultOffW-1:0] : '0;
  assign done_d       = produce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q  <= s_axis_tdata;
      in_first_q <= s_axis_tuser;
      in_last_q  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < MAX_PATTERN; i++) begin
        win_q[i] <= 8'h00;
      end
      pos_q  <= '0;
      done_q <= 1'b0;
    end else if (advance && active) begin
      win_q  <= win_d;
      pos_q  <= pos_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produce) begin
      out_found_q  <= out_found_d;
      out_offset_q <= out_offset_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = out_offset_q;

  // A region that is already finished gives no further result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !in_first_q && done_q) |-> !produce)
    else $error("result produced after the region was finished");

  // Every result issued closes the region.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && produce) |=> done_q)
    else $error("done flag not set after a result");

  // A not-found result always carries a zero offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("not-found result with nonzero offset");

endmodule
